### rtl/gsso_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsso_pkg - shared types and constants of the gated stereo sine oscillator
// Request codes, field widths and the fixed-point constants of the sine ROM.
// ----------------------------------------------------------------------------
package gsso_pkg;

    localparam int FREQ_W = 22;
    localparam int VEL_W  = 8;
    localparam int REQ_W  = 2;

    // velocity that means full scale
    localparam int LEVEL_FULL = 255;

    typedef enum logic [REQ_W-1:0] {
        REQ_NOTE_ON  = 2'd0,
        REQ_NOTE_OFF = 2'd1,
        REQ_TICK     = 2'd2
    } t_req;

    // Q30 fixed-point constants of the table builder
    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1 << 30;

    // divisors (2k)(2k+1) of the Taylor terms, k = 1..7
    localparam longint unsigned SINE_DIV [7] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210
    };

endpackage

### rtl/gated_stereo_sine_oscillator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gated_stereo_sine_oscillator - note-gated stereo wavetable sine source
// Note items set or clear the gate; each tick item yields one stereo sample,
// left at the latched step, right at three times it, scaled by velocity/255.
//
// channel  direction  handshake                  payload
// in       sink       i_in_valid / o_in_stall    i_req_type, i_freq_step,
//                                                i_velocity
// out      source     o_out_valid / i_out_stall  o_left_sample, o_right_sample
//
// One item is taken per cycle while the output is not stalled. The ROM read is
// registered at the edge that takes a tick; velocity multiply, reciprocal
// multiply and correction each add a register stage, the last one the output register.
// Note items act on the state in the cycle they are taken and give no sample.
// Synchronous active-low reset closes the gate and clears step, level,
// accumulators and all pipeline valid bits.
// A stall while a sample waits on the output halts the whole pipeline and
// stalls the input, note items included.
// ----------------------------------------------------------------------------
module gated_stereo_sine_oscillator
    import gsso_pkg::*;
#(
    parameter int TABLE_ENTRIES = 1024,
    parameter int FRAC_BITS     = 12,
    parameter int SAMPLE_BITS   = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [REQ_W-1:0]              i_req_type,
    input  logic [FREQ_W-1:0]             i_freq_step,
    input  logic [VEL_W-1:0]              i_velocity,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [SAMPLE_BITS-1:0] o_left_sample,
    output logic signed [SAMPLE_BITS-1:0] o_right_sample
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int ACC_W = IDX_W + FRAC_BITS;
    localparam int MAG_W = SAMPLE_BITS - 1;
    localparam int PW    = MAG_W + VEL_W;
    localparam longint AMP = (64'sd1 <<< MAG_W) - 64'sd1;
    localparam logic [PW-1:0] RECIP = PW'((64'd1 << PW) / LEVEL_FULL);
    localparam int NCH = 2;

    // Table entry: folded Taylor series in Q30, rounded to the sample width.
    function automatic logic signed [SAMPLE_BITS-1:0] sine_entry(input longint unsigned idx);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          v;
        logic            neg;
        x   = (64'd2 * PI_Q30 * idx) / TABLE_ENTRIES;
        neg = 1'b0;
        if (x >= PI_Q30) begin
            neg = 1'b1;
            x   = x - PI_Q30;
        end
        if (x > PI_Q30 / 2) begin
            x = PI_Q30 - x;
        end
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 0; k < 7; k++) begin
            term = ((term * x2) >> 30) / SINE_DIV[k];
            if (k % 2 == 0) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > longint'(ONE_Q30)) begin
            sum = longint'(ONE_Q30);
        end
        v = (sum * AMP + longint'(ONE_Q30 / 2)) >> 30;
        return neg ? SAMPLE_BITS'(-v) : SAMPLE_BITS'(v);
    endfunction

    logic signed [SAMPLE_BITS-1:0] c_sine [TABLE_ENTRIES];

    for (genvar g = 0; g < TABLE_ENTRIES; g++) begin : g_rom
        assign c_sine[g] = sine_entry(longint'(g));
    end

    // oscillator state
    logic             r_gate;
    logic [ACC_W-1:0] r_step;
    logic [VEL_W-1:0] r_level;
    logic [ACC_W-1:0] r_left_acc;
    logic [ACC_W-1:0] r_right_acc;

    logic             n_gate;
    logic [ACC_W-1:0] n_step;
    logic [VEL_W-1:0] n_level;
    logic [ACC_W-1:0] n_left_acc;
    logic [ACC_W-1:0] n_right_acc;

    // pipeline
    logic                          r_s1_valid;
    logic signed [SAMPLE_BITS-1:0] r_s1_rom [NCH];
    logic [VEL_W-1:0]              r_s1_level;
    logic                          r_s2_valid;
    logic                          r_s2_neg [NCH];
    logic [PW-1:0]                 r_s2_abs [NCH];
    logic                          r_s3_valid;
    logic                          r_s3_neg [NCH];
    logic [PW-1:0]                 r_s3_abs [NCH];
    logic [MAG_W-1:0]              r_s3_q0  [NCH];
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample [NCH];

    logic                          w_adv;
    logic                          w_in_acc;
    logic [ACC_W-1:0]              w_step3;
    logic [MAG_W-1:0]              w_mag [NCH];
    logic [2*PW-1:0]               w_mul [NCH];
    logic [PW-1:0]                 w_rem [NCH];
    logic [MAG_W-1:0]              w_q   [NCH];

    assign w_adv      = !r_out_valid || !i_out_stall;
    assign w_in_acc   = i_in_valid && w_adv;
    assign o_in_stall = !w_adv;
    assign w_step3    = r_step + {r_step[ACC_W-2:0], 1'b0};

    always_comb begin
        n_gate      = r_gate;
        n_step      = r_step;
        n_level     = r_level;
        n_left_acc  = r_left_acc;
        n_right_acc = r_right_acc;
        if (w_in_acc) begin
            case (i_req_type)
                REQ_NOTE_ON: begin
                    n_gate      = 1'b1;
                    n_step      = ACC_W'(i_freq_step);
                    n_level     = i_velocity;
                    n_left_acc  = '0;
                    n_right_acc = '0;
                end
                REQ_NOTE_OFF: begin
                    n_gate = 1'b0;
                end
                REQ_TICK: begin
                    // advance only while the note sounds
                    if (r_gate) begin
                        n_left_acc  = r_left_acc + r_step;
                        n_right_acc = r_right_acc + w_step3;
                    end
                end
                default: begin
                    // unused selector: drop
                end
            endcase
        end
    end

    always_comb begin
        for (int c = 0; c < NCH; c++) begin
            w_mag[c] = r_s1_rom[c][SAMPLE_BITS-1] ? MAG_W'(-r_s1_rom[c])
                                                  : MAG_W'(r_s1_rom[c]);
            w_mul[c] = (2*PW)'(r_s2_abs[c]) * (2*PW)'(RECIP);
            // reciprocal estimate is at most one low; fix with the remainder
            w_rem[c] = r_s3_abs[c]
                     - ((PW'(r_s3_q0[c]) << VEL_W) - PW'(r_s3_q0[c]));
            w_q[c]   = (w_rem[c] >= PW'(LEVEL_FULL)) ? r_s3_q0[c] + 1'b1 : r_s3_q0[c];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate      <= 1'b0;
            r_step      <= '0;
            r_level     <= '0;
            r_left_acc  <= '0;
            r_right_acc <= '0;
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_gate      <= n_gate;
            r_step      <= n_step;
            r_level     <= n_level;
            r_left_acc  <= n_left_acc;
            r_right_acc <= n_right_acc;
            if (w_adv) begin
                r_s1_valid  <= w_in_acc && (i_req_type == REQ_TICK);
                r_s2_valid  <= r_s1_valid;
                r_s3_valid  <= r_s2_valid;
                r_out_valid <= r_s3_valid;
            end
        end
    end

    // payload stages, no reset
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_rom[0] <= c_sine[r_left_acc[ACC_W-1:FRAC_BITS]];
            r_s1_rom[1] <= c_sine[r_right_acc[ACC_W-1:FRAC_BITS]];
            // a closed gate scales the sample to zero
            r_s1_level  <= r_gate ? r_level : '0;
            for (int c = 0; c < NCH; c++) begin
                r_s2_neg[c]     <= r_s1_rom[c][SAMPLE_BITS-1];
                r_s2_abs[c]     <= PW'(w_mag[c]) * PW'(r_s1_level);
                r_s3_neg[c]     <= r_s2_neg[c];
                r_s3_abs[c]     <= r_s2_abs[c];
                r_s3_q0[c]      <= w_mul[c][PW +: MAG_W];
                r_out_sample[c] <= r_s3_neg[c] ? -SAMPLE_BITS'(w_q[c])
                                               : SAMPLE_BITS'(w_q[c]);
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_left_sample  = r_out_sample[0];
    assign o_right_sample = r_out_sample[1];

    a_note_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_req_type != REQ_TICK) |=> !r_s1_valid)
        else $error("note item entered the sample pipeline");

    a_closed_gate_mute: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_req_type == REQ_TICK) && !r_gate |=> r_s1_level == '0)
        else $error("tick with closed gate not muted");

    a_note_on_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && (i_req_type == REQ_NOTE_ON)
        |=> r_gate && (r_left_acc == '0) && (r_right_acc == '0))
        else $error("note on did not retrigger the oscillator");

    a_quotient_close: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s3_valid |-> (w_rem[0] < PW'(2 * LEVEL_FULL)) && (w_rem[1] < PW'(2 * LEVEL_FULL)))
        else $error("reciprocal estimate more than one below the quotient");

endmodule

### tb/gsso_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsso_checker - sample predictor and scoreboard for the sine oscillator
// Watches both channels and keeps its own gate, step, level and phase state.
// For every accepted tick it queues the expected stereo pair, then compares
// each accepted output sample against the oldest pair in the queue.
// ----------------------------------------------------------------------------
module gsso_checker
    import gsso_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_stall,
    input  logic [REQ_W-1:0]        i_req_type,
    input  logic [FREQ_W-1:0]       i_freq_step,
    input  logic [VEL_W-1:0]        i_velocity,
    input  logic                    i_out_valid,
    input  logic                    i_out_stall,
    input  logic signed [15:0]      i_left_sample,
    input  logic signed [15:0]      i_right_sample,
    output int                      o_fail_count,
    output int                      o_pending
);

    localparam int                TAB_BITS      = 10;
    localparam longint unsigned   TAB_SIZE      = 64'd1024;
    localparam int                OUT_W         = 16;
    localparam int                VEL_FULL      = 255;
    localparam longint            SINE_PEAK     = 64'sd32767;
    localparam longint unsigned   HALF_TURN_Q30 = 64'd3373259426;
    localparam longint unsigned   UNITY_Q30     = 64'd1 << 30;

    typedef struct packed {
        logic signed [OUT_W-1:0] left_val;
        logic signed [OUT_W-1:0] right_val;
    } t_stereo;

    logic signed [OUT_W-1:0] sine_tab [1024];
    t_stereo                 sample_queue [$];

    logic                    gate_on;
    logic [FREQ_W-1:0]       step_reg;
    logic [VEL_W-1:0]        level_reg;
    logic [FREQ_W-1:0]       left_phase;
    logic [FREQ_W-1:0]       right_phase;

    // one table entry: angle folded into the first quadrant, Taylor sum in Q30
    function automatic logic signed [OUT_W-1:0] sine_point(int unsigned idx);
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned term;
        longint          sum;
        longint          rounded;
        bit              neg;
        ang = (2 * HALF_TURN_Q30 * 64'(idx)) / TAB_SIZE;
        neg = 1'b0;
        if (ang >= HALF_TURN_Q30) begin
            neg = 1'b1;
            ang = ang - HALF_TURN_Q30;
        end
        if (ang > HALF_TURN_Q30 / 2) begin
            ang = HALF_TURN_Q30 - ang;
        end
        ang_sq = (ang * ang) >> 30;
        term   = ang;
        sum    = longint'(ang);
        for (int k = 1; k <= 7; k++) begin
            term = ((term * ang_sq) >> 30) / 64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > longint'(UNITY_Q30)) begin
            sum = longint'(UNITY_Q30);
        end
        rounded = (sum * SINE_PEAK + longint'(UNITY_Q30 / 2)) >>> 30;
        return neg ? OUT_W'(-rounded) : OUT_W'(rounded);
    endfunction

    // table lookup at the integer part of the phase, scaled by level/255
    function automatic logic signed [OUT_W-1:0] apply_level(logic [FREQ_W-1:0] phase);
        int prod;
        prod = int'(sine_tab[phase[FREQ_W-1 -: TAB_BITS]]) * int'(level_reg);
        return OUT_W'(prod / VEL_FULL);
    endfunction

    task automatic report_mismatch(input string msg);
        $display("%0t ns: %s", $time, msg);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        for (int i = 0; i < 1024; i++) begin
            sine_tab[i] = sine_point(i);
        end
    end

    // sample at the falling edge: values are settled and match the next rising edge
    always @(negedge i_clk) begin
        t_stereo want;
        if (!i_rst_n) begin
            gate_on     = 1'b0;
            step_reg    = '0;
            level_reg   = '0;
            left_phase  = '0;
            right_phase = '0;
            sample_queue.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (sample_queue.size() == 0) begin
                    report_mismatch($sformatf("sample with nothing pending: left %0d right %0d",
                                              i_left_sample, i_right_sample));
                end else begin
                    want = sample_queue.pop_front();
                    if (i_left_sample !== want.left_val) begin
                        report_mismatch($sformatf("left_sample got %0d expected %0d",
                                                  i_left_sample, want.left_val));
                    end
                    if (i_right_sample !== want.right_val) begin
                        report_mismatch($sformatf("right_sample got %0d expected %0d",
                                                  i_right_sample, want.right_val));
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                case (i_req_type)
                    REQ_NOTE_ON: begin
                        gate_on     = 1'b1;
                        step_reg    = i_freq_step;
                        level_reg   = i_velocity;
                        left_phase  = '0;
                        right_phase = '0;
                    end
                    REQ_NOTE_OFF: begin
                        gate_on = 1'b0;
                    end
                    REQ_TICK: begin
                        if (!gate_on) begin
                            want = '0;
                        end else begin
                            want.left_val  = apply_level(left_phase);
                            want.right_val = apply_level(right_phase);
                            // phase wraps at the table length, i.e. the register width
                            left_phase  = left_phase + step_reg;
                            right_phase = right_phase + FREQ_W'(3 * step_reg);
                        end
                        sample_queue.push_back(want);
                    end
                    default: begin
                        // unused selector: drop
                    end
                endcase
            end
        end
        o_pending = sample_queue.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - regression for the gated stereo sine oscillator
// Drives a short directed sequence (silence, peaks, wrap, retrigger, zero
// and unit velocity, unused selector) and then random note-on / tick bursts
// with noise, under random input gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_top;
    import gsso_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED   = 2'd3;
    localparam int               TARGET_ITEMS = 750;
    localparam int               DRAIN_CYCLES = 16;
    localparam logic [FREQ_W-1:0] QUARTER_STEP = 22'd256 << 12;
    localparam logic [FREQ_W-1:0] ONE_ENTRY    = 22'd1 << 12;

    logic                   i_clk          = 1'b0;
    logic                   i_rst_n        = 1'b0;
    logic                   i_in_valid     = 1'b0;
    logic [REQ_W-1:0]       i_req_type     = '0;
    logic [FREQ_W-1:0]      i_freq_step    = '0;
    logic [VEL_W-1:0]       i_velocity     = '0;
    logic                   i_out_stall    = 1'b0;
    logic                   o_in_stall;
    logic                   o_out_valid;
    logic signed [15:0]     o_left_sample;
    logic signed [15:0]     o_right_sample;

    int                     fail_count;
    int                     pending;
    int                     item_count     = 0;
    int                     calm_items     = 0;
    int unsigned            stall_hold     = 0;
    int unsigned            calm_cycles    = 0;

    gated_stereo_sine_oscillator dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_freq_step    (i_freq_step),
        .i_velocity     (i_velocity),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_left_sample  (o_left_sample),
        .o_right_sample (o_right_sample)
    );

    gsso_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_req_type     (i_req_type),
        .i_freq_step    (i_freq_step),
        .i_velocity     (i_velocity),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_left_sample  (o_left_sample),
        .i_right_sample (o_right_sample),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // output back-pressure: short and long stalls, with calm stretches between
    always @(posedge i_clk) begin
        int roll;
        if (stall_hold != 0) begin
            stall_hold <= stall_hold - 1;
        end else if (calm_cycles != 0) begin
            calm_cycles <= calm_cycles - 1;
            i_out_stall <= 1'b0;
        end else begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                i_out_stall <= 1'b0;
                calm_cycles <= $urandom_range(50, 200);
            end else if (roll < 60) begin
                i_out_stall <= 1'b0;
            end else if (roll < 95) begin
                i_out_stall <= 1'b1;
                stall_hold  <= $urandom_range(0, 3);
            end else begin
                i_out_stall <= 1'b1;
                stall_hold  <= $urandom_range(10, 40);
            end
        end
    end

    // present one item after a random gap and hold it until taken
    task automatic push_item(input logic [REQ_W-1:0] req, input logic [FREQ_W-1:0] step,
                             input logic [VEL_W-1:0] vel);
        int gap;
        int roll;
        roll = $urandom_range(0, 99);
        if (calm_items > 0) begin
            calm_items--;
            gap = 0;
        end else if (roll < 3) begin
            calm_items = $urandom_range(20, 60);
            gap = 0;
        end else if (roll < 70) begin
            gap = 0;
        end else if (roll < 93) begin
            gap = $urandom_range(1, 3);
        end else begin
            gap = $urandom_range(8, 40);
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= req;
        i_freq_step <= step;
        i_velocity  <= vel;
        do @(negedge i_clk); while (o_in_stall);
        @(posedge i_clk);
        if (req != REQ_UNUSED) begin
            item_count++;
        end
    endtask

    function automatic logic [FREQ_W-1:0] random_step();
        case ($urandom_range(0, 3))
            0:       return FREQ_W'($urandom_range(0, 1 << 14));
            1:       return FREQ_W'($urandom);
            2:       return FREQ_W'($urandom_range(0, 1023)) << 12;
            default: return 22'h3FFFFF - FREQ_W'($urandom_range(0, 4095));
        endcase
    endfunction

    initial begin
        logic [VEL_W-1:0] vel;
        int               roll;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // silence straight after reset
        push_item(REQ_TICK, '1, '1);
        // zero step stays at table entry zero
        push_item(REQ_NOTE_ON, '0, 8'd255);
        push_item(REQ_TICK, '0, '0);
        push_item(REQ_TICK, '0, '0);
        // quarter-turn step walks through both peaks
        push_item(REQ_NOTE_ON, QUARTER_STEP, 8'd255);
        repeat (5) push_item(REQ_TICK, '0, '0);
        // largest step wraps the phase
        push_item(REQ_NOTE_ON, 22'h3FFFFF, 8'd255);
        repeat (3) push_item(REQ_TICK, '1, '1);
        // retrigger while the gate is open, unit velocity
        push_item(REQ_NOTE_ON, ONE_ENTRY + 22'd5, 8'd1);
        repeat (2) push_item(REQ_TICK, '0, '0);
        // zero velocity mutes an open gate
        push_item(REQ_NOTE_ON, QUARTER_STEP + 22'd77, 8'd0);
        push_item(REQ_TICK, '0, '0);
        // note off, then the unused selector, then silence
        push_item(REQ_NOTE_OFF, '1, '1);
        push_item(REQ_TICK, '0, '0);
        push_item(REQ_UNUSED, '1, '1);
        push_item(REQ_TICK, '0, '0);
        push_item(REQ_NOTE_ON, 22'h2AAAAA, 8'h80);
        push_item(REQ_TICK, '0, '0);

        while (item_count < TARGET_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 80) begin
                case ($urandom_range(0, 7))
                    0:       vel = '0;
                    1:       vel = 8'd255;
                    default: vel = VEL_W'($urandom);
                endcase
                push_item(REQ_NOTE_ON, random_step(), vel);
                repeat ($urandom_range(1, 24)) push_item(REQ_TICK, FREQ_W'($urandom),
                                                         VEL_W'($urandom));
                if ($urandom_range(0, 1) == 1) begin
                    push_item(REQ_NOTE_OFF, FREQ_W'($urandom), VEL_W'($urandom));
                    repeat ($urandom_range(0, 3)) push_item(REQ_TICK, FREQ_W'($urandom),
                                                            VEL_W'($urandom));
                end
            end else begin
                push_item(REQ_W'($urandom_range(0, 3)), random_step(), VEL_W'($urandom));
            end
        end
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("gated_stereo_sine_oscillator regression: pass");
        end else begin
            $display("gated_stereo_sine_oscillator regression: fail");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("gated_stereo_sine_oscillator regression: fail");
        $finish;
    end

endmodule
